@@ rtl/core/bce_pkg.sv @@
// ----------------------------------------------------------------------------
// bce_pkg
// shared types and constants for the binomial coefficient engine
// ----------------------------------------------------------------------------
package bce_pkg;

    localparam int FIELD_W = 6;
    localparam int OUT_W   = 64;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic prep;
        logic mul;
        logic div_step;
        logic out_load;
    } bce_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic special;
        logic div_last;
        logic iter_last;
    } bce_status_t;

endpackage

@@ rtl/core/bce_ctrl.sv @@
// ----------------------------------------------------------------------------
// bce_ctrl
// sequencer: capture, reduce, multiply and bit-serial divide, hand over result
// ----------------------------------------------------------------------------
module bce_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bce_pkg::bce_cmd_t    cmd,
    input  bce_pkg::bce_status_t status
);
    import bce_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PREP = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = status.special ? ST_OUT : ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = status.iter_last ? ST_OUT : ST_MUL;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ rtl/core/bce_dp.sv @@
// ----------------------------------------------------------------------------
// bce_dp
// datapath: operand reduction, one multiply per step, restoring divider
// ----------------------------------------------------------------------------
module bce_dp #(
    parameter int RESULT_WIDTH = 64
) (
    input  logic                         aclk,
    input  logic [bce_pkg::FIELD_W-1:0]  set_size,
    input  logic [bce_pkg::FIELD_W-1:0]  subset_size,
    input  bce_pkg::bce_cmd_t            cmd,
    output bce_pkg::bce_status_t         status,
    output logic [bce_pkg::OUT_W-1:0]    coefficient
);
    import bce_pkg::*;

    localparam int W    = RESULT_WIDTH;
    localparam int CNTW = $clog2(W);
    localparam int REMW = FIELD_W - 1;

    logic [FIELD_W-1:0] n_reg, k_reg, base_reg, i_reg;
    logic [W-1:0]       acc_reg, q_reg, out_reg;
    logic [REMW-1:0]    rem_reg;
    logic [CNTW-1:0]    cnt_reg;

    logic               k_gt_n, trivial;
    logic [FIELD_W-1:0] n_minus_k, k_eff, factor;
    logic [W+FIELD_W-1:0] prod_full;
    logic [REMW:0]      r_trial;
    logic               q_bit;
    logic [W-1:0]       q_next;
    logic [REMW-1:0]    rem_next;

    // special cases and symmetry reduction on the captured operands
    assign k_gt_n    = k_reg > n_reg;
    assign trivial   = (k_reg == '0) || (k_reg == n_reg);
    assign n_minus_k = n_reg - k_reg;
    assign k_eff     = (k_reg > n_minus_k) ? n_minus_k : k_reg;

    assign factor    = base_reg + i_reg;
    assign prod_full = (W + FIELD_W)'(acc_reg) * (W + FIELD_W)'(factor);

    // one quotient bit per cycle, divisor is at most 31
    assign r_trial  = {rem_reg, q_reg[W-1]};
    assign q_bit    = (r_trial >= i_reg);
    assign rem_next = q_bit ? REMW'(r_trial - i_reg) : r_trial[REMW-1:0];
    assign q_next   = {q_reg[W-2:0], q_bit};

    assign status.special   = k_gt_n || trivial;
    assign status.div_last  = (cnt_reg == CNTW'(W - 1));
    assign status.iter_last = (i_reg == k_reg);

    assign coefficient = OUT_W'(out_reg);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            n_reg <= set_size;
            k_reg <= subset_size;
        end
        if (cmd.prep) begin
            k_reg    <= k_eff;
            base_reg <= n_reg - k_eff;
            i_reg    <= FIELD_W'(1);
            acc_reg  <= k_gt_n ? '0 : W'(1);
        end
        if (cmd.mul) begin
            q_reg   <= prod_full[W-1:0];
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        if (cmd.div_step) begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + CNTW'(1);
            if (status.div_last) begin
                acc_reg <= q_next;
                i_reg   <= i_reg + FIELD_W'(1);
            end
        end
        if (cmd.out_load) begin
            out_reg <= acc_reg;
        end
    end

endmodule

@@ rtl/core/binomial_coefficient_engine_top.sv @@
// Returns n choose k for each request, one transaction at a time. A request
// with k greater than n, k of zero or k equal to n goes from the reduction
// straight to the output register; otherwise k is reduced to k' = min(k, n-k)
// and the block runs k' rounds of one multiply followed by the restoring
// divider, which produces one quotient bit per cycle after each multiply.
// Intermediate products wrap modulo 2^RESULT_WIDTH before each division and
// the upper bits of the 64-bit result above RESULT_WIDTH are zero. A finished
// result waits in the output register, so a new request is taken as soon as
// it has been handed over to that register.
// ----------------------------------------------------------------------------
// binomial_coefficient_engine_top
// multiplicative binomial coefficient with controller and serial datapath
// ----------------------------------------------------------------------------
module binomial_coefficient_engine_top #(
    parameter int RESULT_WIDTH = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [bce_pkg::FIELD_W-1:0]  s_set_size,
    input  logic [bce_pkg::FIELD_W-1:0]  s_subset_size,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [bce_pkg::OUT_W-1:0]    m_coefficient
);
    import bce_pkg::*;

    bce_cmd_t    cmd;
    bce_status_t status;

    bce_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    bce_dp #(
        .RESULT_WIDTH (RESULT_WIDTH)
    ) u_dp (
        .aclk        (aclk),
        .set_size    (s_set_size),
        .subset_size (s_subset_size),
        .cmd         (cmd),
        .status      (status),
        .coefficient (m_coefficient)
    );

`ifndef NO_ASSERTIONS
    // only one transaction in flight
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a transaction is in progress");

    // result register never overwritten while still held
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("result overwritten before hand-over");

    a_cmd_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.capture, cmd.prep, cmd.mul, cmd.div_step, cmd.out_load}))
        else $error("conflicting datapath commands");

    // nothing above the configured result width
    a_upper_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_coefficient >> RESULT_WIDTH) == 64'd0))
        else $error("result bits above configured width");
`endif

endmodule

@@ dv/tb_binomial_coefficient_engine_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binomial_coefficient_engine_top
// self-checking bench for the binomial coefficient engine: requests of set
// size and subset size are sent with random gaps and back-pressure, and every
// returned coefficient is compared with a wrapped multiplicative prediction
// ----------------------------------------------------------------------------
module tb_binomial_coefficient_engine_top;

    localparam int RESULT_WIDTH   = 64;
    localparam int WATCHDOG_LIMIT = 12000;
    localparam int DRAIN_CYCLES   = 2100;

    typedef struct {
        bit [5:0]  n;
        bit [5:0]  k;
        bit [63:0] coeff;
    } binom_request_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic [bce_pkg::FIELD_W-1:0]  s_set_size = '0;
    logic [bce_pkg::FIELD_W-1:0]  s_subset_size = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [bce_pkg::OUT_W-1:0]    m_coefficient;

    binom_request_t pending_coefficients[$];
    bit             idling_on = 1'b1;
    int             error_count = 0;
    int             requests_sent = 0;
    int             results_checked = 0;
    int             special_requests = 0;
    int             widest_reduced_k = 0;
    int             idle_cycles = 0;
    int             ready_hold = 0;

    binomial_coefficient_engine_top #(
        .RESULT_WIDTH(RESULT_WIDTH)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_set_size    (s_set_size),
        .s_subset_size (s_subset_size),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_coefficient (m_coefficient)
    );

    always #5 aclk = ~aclk;

    // n choose k by the multiplicative method, each product wrapped before dividing
    function automatic bit [63:0] choose_wrapped(bit [5:0] n, bit [5:0] k);
        bit [63:0] mask;
        bit [63:0] acc;
        bit [63:0] prod;
        bit [63:0] nn;
        bit [63:0] kk;
        bit [63:0] i;
        mask = ~64'd0 >> (64 - RESULT_WIDTH);
        if (k > n) return 64'd0;
        if (k == 0 || k == n) return 64'd1;
        nn = 64'(n);
        kk = 64'(k);
        if (kk > nn - kk) kk = nn - kk;
        acc = 64'd1;
        for (i = 64'd1; i <= kk; i++) begin
            prod = (acc * (nn - kk + i)) & mask;
            acc  = prod / i;
        end
        return acc & mask;
    endfunction

    // back to back half the time, sometimes short pauses, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // starts at the falling edge after the previous transaction
    task automatic send_request(input bit [5:0] n, input bit [5:0] k);
        binom_request_t req;
        int             gap;
        int             reduced;
        gap = idling_on ? pick_gap() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_set_size    <= n;
        s_subset_size <= k;
        do @(posedge aclk); while (!s_ready);
        req.n     = n;
        req.k     = k;
        req.coeff = choose_wrapped(n, k);
        pending_coefficients.push_back(req);
        requests_sent++;
        if (k > n || k == 0 || k == n) begin
            special_requests++;
        end else begin
            reduced = (k > n - k) ? int'(n - k) : int'(k);
            if (reduced > widest_reduced_k) widest_reduced_k = reduced;
        end
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // result side back-pressure
    always @(negedge aclk) begin
        if (!idling_on) begin
            m_ready    <= 1'b1;
            ready_hold <= 0;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (m_ready) begin
            ready_hold <= pick_gap();
            m_ready    <= 1'b0;
        end else begin
            ready_hold <= $urandom_range(0, 20);
            m_ready    <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        binom_request_t req;
        if (aresetn && m_valid && m_ready) begin
            if (pending_coefficients.size() == 0) begin
                report_mismatch($sformatf("unexpected coefficient 0x%016h", m_coefficient));
            end else begin
                req = pending_coefficients.pop_front();
                results_checked++;
                if (m_coefficient !== req.coeff)
                    report_mismatch($sformatf("%0d choose %0d: got 0x%016h, want 0x%016h",
                                              req.n, req.k, m_coefficient, req.coeff));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("binomial_coefficient_engine_top test failed");
                $finish;
            end
        end
    end

    // subset above set, empty subset and full subset
    task automatic test_special_cases();
        send_request(6'd0, 6'd0);
        send_request(6'd63, 6'd63);
        send_request(6'd0, 6'd63);
        send_request(6'd62, 6'd63);
        send_request(6'd63, 6'd0);
        send_request(6'd0, 6'd1);
        send_request(6'd1, 6'd0);
        send_request(6'd1, 6'd1);
        send_request(6'd21, 6'd42);
        send_request(6'd42, 6'd42);
    endtask

    // small exact cases and the n-k reduction
    task automatic test_symmetry_and_small();
        send_request(6'd2, 6'd1);
        send_request(6'd10, 6'd3);
        send_request(6'd10, 6'd7);
        send_request(6'd6, 6'd3);
        send_request(6'd63, 6'd1);
        send_request(6'd63, 6'd62);
        send_request(6'd42, 6'd21);
    endtask

    // large reduced subsets, where products can wrap
    task automatic test_wrapped_products();
        send_request(6'd62, 6'd31);
        send_request(6'd63, 6'd31);
        send_request(6'd63, 6'd32);
        send_request(6'd61, 6'd30);
        send_request(6'd60, 6'd30);
        send_request(6'd63, 6'd21);
    endtask

    task automatic test_random_small_sets(input int count);
        bit [5:0] n;
        for (int i = 0; i < count; i++) begin
            n = 6'($urandom_range(0, 20));
            send_request(n, 6'($urandom_range(0, n + 2)));
        end
    endtask

    task automatic test_random_full_range(input int count);
        for (int i = 0; i < count; i++)
            send_request(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
    endtask

    // no gaps on either side
    task automatic test_back_to_back(input int count);
        bit [5:0] n;
        idling_on = 1'b0;
        for (int i = 0; i < count; i++) begin
            n = 6'($urandom_range(0, 63));
            if ($urandom_range(0, 3) == 0)
                send_request(n, 6'($urandom_range(0, 63)));
            else
                send_request(n, 6'($urandom_range(0, n < 12 ? n : 12)));
        end
        idling_on = 1'b1;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_special_cases();
        test_symmetry_and_small();
        test_wrapped_products();
        test_random_small_sets(120);
        test_random_full_range(100);
        test_back_to_back(40);
        stop_sending();

        wait (pending_coefficients.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d requests, %0d coefficients checked, %0d of them special cases",
                 requests_sent, results_checked, special_requests);
        $display("largest reduced subset size reached: %0d", widest_reduced_k);
        if (error_count == 0)
            $display("binomial_coefficient_engine_top test passed");
        else
            $display("binomial_coefficient_engine_top test failed");
        $finish;
    end

endmodule
